// File: rtl/mept_pkg.sv
// ============================================================================
// mept_pkg: shared types and constants for the multi-turn encoder tracker
// Register codes, controller states, command/status bundles, saturation.
// ============================================================================
package mept_pkg;

    // Payload widths of the channels
    localparam int RAW_W      = 16;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int TURN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int CPR_CFG_W  = 17;
    localparam int THR_W      = 16;
    localparam int DT_W       = 16;

    // Divider: full quotient width and the short (re-centre) pass width
    localparam int DVD_W = 33;
    localparam int MOD_W = RAW_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

    localparam logic [CPR_CFG_W-1:0] CPR_RESET    = 17'd16384;
    localparam logic [THR_W-1:0]     THRESH_RESET = 16'd9000;

    localparam logic signed [POS_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_MUL,
        S_POS,
        S_DTCHK,
        S_VEL,
        S_ACC_GO,
        S_ACC,
        S_COMMIT,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch request, start re-centre division
        logic centre;     // fold remainder into centred count
        logic turn;       // update turn counter
        logic mul;        // turns * counts per rev
        logic pos;        // form saturated position
        logic vel_start;  // start position-delta division
        logic vel;        // take velocity quotient
        logic acc_start;  // start velocity-delta division
        logic acc;        // take acceleration quotient, update time/velocity
        logic commit;     // update previous count and position
        logic out_load;   // load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic same;       // centred count unchanged
        logic dt_pos;     // 16-bit time difference is positive
        logic out_free;   // result register can take a new result
    } t_dp_status;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = SAT_MAX;
        end else if (v < -64'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Apply a sign to an unsigned quotient and saturate to 32 bits
    function automatic logic signed [POS_W-1:0] sat_sm(input logic neg,
                                                      input logic [DVD_W-1:0] q);
        logic [DVD_W-1:0]        nq;
        logic signed [POS_W-1:0] r;
        nq = -q;
        if (neg) begin
            r = (q > 33'h0_8000_0000) ? SAT_MIN : nq[POS_W-1:0];
        end else begin
            r = (q > 33'h0_7FFF_FFFF) ? SAT_MAX : q[POS_W-1:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value, one bit wider
    function automatic logic [POS_W:0] abs33(input logic signed [POS_W-1:0] v);
        logic [POS_W:0] e;
        e = {v[POS_W-1], v};
        return v[POS_W-1] ? -e : e;
    endfunction

endpackage

// File: rtl/mept_if.sv
// ============================================================================
// mept_if: channel interfaces of the multi-turn encoder tracker
// Sample request, result request and configuration write channels.
// ============================================================================

// Encoder sample request
interface mept_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_count;
    logic [31:0] time_ms;

    modport source (output valid, output raw_count, output time_ms, input ready);
    modport sink   (input valid, input raw_count, input time_ms, output ready);
endinterface

// Tracker result request
interface mept_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic signed [15:0] turn_count;

    modport source (output valid, output position, output velocity,
                    output acceleration, output turn_count, input ready);
    modport sink   (input valid, input position, input velocity,
                    input acceleration, input turn_count, output ready);
endinterface

// Configuration register write
interface mept_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mept_div.sv
// ============================================================================
// mept_div: iterative restoring divider
// One quotient bit per cycle; a short pass of SHORT_W steps gives a remainder.
// ============================================================================
module mept_div
    import mept_pkg::*;
#(
    parameter int DVD_W_P = 33,
    parameter int DVS_W   = 17,
    parameter int SHORT_W = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_short,
    input  logic [DVD_W_P-1:0] i_dividend,
    input  logic [DVS_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DVD_W_P-1:0] o_quot,
    output logic [DVS_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(DVD_W_P + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVS_W-1:0]   r_rem;
    logic [DVD_W_P-1:0] r_q;
    logic [DVS_W-1:0]   r_dvs;

    logic [DVS_W+1:0]   w_trial;
    logic [DVS_W:0]     w_shift;
    logic               w_ge;

    // Trial subtract of the shifted partial remainder
    assign w_shift = {r_rem, r_q[DVD_W_P-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_trial[DVS_W+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? CNT_W'(SHORT_W) : CNT_W'(DVD_W_P);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_short ? {i_dividend[SHORT_W-1:0], {(DVD_W_P-SHORT_W){1'b0}}}
                             : i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_q   <= {r_q[DVD_W_P-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    // A start only arrives while the unit is free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not go busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");

endmodule

// File: rtl/mept_dp.sv
// ============================================================================
// mept_dp: tracker datapath
// Config registers, tracking state, multiplier, divider and result register.
// ============================================================================
module mept_dp
    import mept_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample payload
    input  logic [RAW_W-1:0]       i_raw_count,
    input  logic [TIME_W-1:0]      i_time_ms,
    // result channel
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic signed [POS_W-1:0]  o_position,
    output logic signed [POS_W-1:0]  o_velocity,
    output logic signed [POS_W-1:0]  o_acceleration,
    output logic signed [TURN_W-1:0] o_turn_count,
    // controller link
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status
);

    localparam int CW     = COUNT_WIDTH;
    localparam int CPR_W  = CW + 1;
    localparam int CMP_W  = (CPR_W > CPR_CFG_W) ? CPR_W : CPR_CFG_W;
    localparam int DVS_W  = (CPR_W > DT_W) ? CPR_W : DT_W;
    localparam int CH_W   = ((CW > THR_W) ? CW : THR_W) + 2;
    localparam int PROD_W = TURN_W + CPR_W + 1;

    // Configuration
    logic [CPR_CFG_W-1:0] r_cfg_cpr;
    logic [RAW_W-1:0]     r_cfg_center;
    logic [THR_W-1:0]     r_cfg_thr;

    // Tracking state
    logic [CW-1:0]             r_prev;
    logic signed [TURN_W-1:0]  r_turns;
    logic signed [POS_W-1:0]   r_last_pos;
    logic [TIME_W-1:0]         r_last_time;
    logic signed [POS_W-1:0]   r_last_vel;
    logic signed [POS_W-1:0]   r_acc;

    // Working registers
    logic [TIME_W-1:0]         r_time;
    logic [CW-1:0]             r_centred;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [POS_W-1:0]   r_pos_new;
    logic signed [POS_W-1:0]   r_vel_new;
    logic                      r_div_neg;

    // Result register
    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_out_pos;
    logic signed [POS_W-1:0]   r_out_vel;
    logic signed [POS_W-1:0]   r_out_acc;
    logic signed [TURN_W-1:0]  r_out_turns;

    logic [CMP_W-1:0]          w_cpr_ext;
    logic [CMP_W-1:0]          w_cpr_max;
    logic [CPR_W-1:0]          w_cpr;
    logic [MOD_W-1:0]          w_d;
    logic [MOD_W-1:0]          w_dmag;
    logic [DVS_W-1:0]          w_fix;
    logic signed [CH_W-1:0]    w_change;
    logic signed [CH_W-1:0]    w_thr;
    logic signed [63:0]        w_prod64;
    logic signed [63:0]        w_cen64;
    logic signed [63:0]        w_sum;
    logic [DT_W-1:0]           w_tdiff;
    logic [DVD_W-1:0]          w_pdiff;
    logic [DVD_W-1:0]          w_pmag;
    logic [DVD_W-1:0]          w_dv;
    logic [DVD_W-1:0]          w_dvmag;
    logic                      w_div_start;
    logic [DVD_W-1:0]          w_dvd;
    logic [DVS_W-1:0]          w_dvs;
    logic                      w_div_done;
    logic [DVD_W-1:0]          w_quot;
    logic [DVS_W-1:0]          w_rem;

    // Effective counts per revolution, clamped to 2 .. 2^COUNT_WIDTH
    assign w_cpr_ext = CMP_W'(r_cfg_cpr);
    assign w_cpr_max = CMP_W'(1) << CW;
    always_comb begin
        if (w_cpr_ext < CMP_W'(2)) begin
            w_cpr = CPR_W'(2);
        end else if (w_cpr_ext > w_cpr_max) begin
            w_cpr = w_cpr_max[CPR_W-1:0];
        end else begin
            w_cpr = w_cpr_ext[CPR_W-1:0];
        end
    end

    // Raw minus centre, as sign and magnitude
    assign w_d    = {1'b0, i_raw_count} - {1'b0, r_cfg_center};
    assign w_dmag = w_d[MOD_W-1] ? -w_d : w_d;
    assign w_fix  = DVS_W'(w_cpr) - w_rem;

    // Jump against threshold
    assign w_change = CH_W'(r_centred) - CH_W'(r_prev);
    assign w_thr    = CH_W'(r_cfg_thr);

    // Position sum before saturation
    assign w_prod64 = 64'(r_prod);
    assign w_cen64  = 64'(r_centred);
    assign w_sum    = w_prod64 + w_cen64;

    // Time step and the two deltas to divide
    assign w_tdiff = r_time[DT_W-1:0] - r_last_time[DT_W-1:0];
    assign w_pdiff = {r_pos_new[POS_W-1], r_pos_new} - {r_last_pos[POS_W-1], r_last_pos};
    assign w_pmag  = w_pdiff[DVD_W-1] ? -w_pdiff : w_pdiff;
    assign w_dv    = abs33(r_vel_new) - abs33(r_last_vel);
    assign w_dvmag = w_dv[DVD_W-1] ? -w_dv : w_dv;

    // Divider operand select
    assign w_div_start = i_cmd.load | i_cmd.vel_start | i_cmd.acc_start;
    always_comb begin
        if (i_cmd.load) begin
            w_dvd = DVD_W'(w_dmag);
            w_dvs = DVS_W'(w_cpr);
        end else if (i_cmd.vel_start) begin
            w_dvd = w_pmag;
            w_dvs = DVS_W'(w_tdiff);
        end else begin
            w_dvd = w_dvmag;
            w_dvs = DVS_W'(w_tdiff);
        end
    end

    mept_div #(
        .DVD_W_P (DVD_W),
        .DVS_W   (DVS_W),
        .SHORT_W (MOD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_short    (i_cmd.load),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cpr    <= CPR_RESET;
            r_cfg_center <= '0;
            r_cfg_thr    <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CPR:    r_cfg_cpr    <= i_cfg_data[CPR_CFG_W-1:0];
                CFG_CENTER: r_cfg_center <= i_cfg_data[RAW_W-1:0];
                CFG_THRESH: r_cfg_thr    <= i_cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_turns     <= '0;
            r_last_pos  <= '0;
            r_last_time <= '0;
            r_last_vel  <= '0;
            r_acc       <= '0;
        end else begin
            // turn counter, saturating
            if (i_cmd.turn) begin
                if (w_change > w_thr) begin
                    if (r_turns != 16'sh8000) r_turns <= r_turns - 16'sd1;
                end else if (w_change < -w_thr) begin
                    if (r_turns != 16'sh7FFF) r_turns <= r_turns + 16'sd1;
                end
            end
            if (i_cmd.acc) begin
                r_acc       <= sat_sm(r_div_neg, w_quot);
                r_last_vel  <= r_vel_new;
                r_last_time <= r_time;
            end
            if (i_cmd.commit) begin
                r_prev     <= r_centred;
                r_last_pos <= r_pos_new;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= i_time_ms;
        end
        if (w_div_start) begin
            if (i_cmd.load) begin
                r_div_neg <= w_d[MOD_W-1];
            end else if (i_cmd.vel_start) begin
                r_div_neg <= w_pdiff[DVD_W-1];
            end else begin
                r_div_neg <= w_dv[DVD_W-1];
            end
        end
        // negative offset with a nonzero remainder folds back into range
        if (i_cmd.centre) begin
            r_centred <= (r_div_neg && (w_rem != '0)) ? w_fix[CW-1:0] : w_rem[CW-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_turns) * PROD_W'($signed({1'b0, w_cpr}));
        end
        if (i_cmd.pos) begin
            r_pos_new <= sat32(w_sum);
        end
        if (i_cmd.vel) begin
            r_vel_new <= sat_sm(r_div_neg, w_quot);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos   <= r_last_pos;
            r_out_vel   <= r_last_vel;
            r_out_acc   <= r_acc;
            r_out_turns <= r_turns;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;
    assign o_turn_count   = r_out_turns;

    // Status to controller
    assign o_status.div_done = w_div_done;
    assign o_status.same     = (r_centred == r_prev);
    assign o_status.dt_pos   = ~w_tdiff[DT_W-1] & (w_tdiff != '0);
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    // The turn counter moves by at most one revolution per request
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_turns) |-> (r_turns - $past(r_turns) == 16'sd1 ||
                               r_turns - $past(r_turns) == -16'sd1))
        else $error("turn counter jumped by more than one");
    // A waiting result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped before it was taken");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_out_pos) && $stable(r_out_turns)))
        else $error("result changed while waiting");

endmodule

// File: rtl/mept_ctrl.sv
// ============================================================================
// mept_ctrl: tracker sequencer
// Walks one request through re-centre, turn, position and rate steps.
// ============================================================================
module mept_ctrl
    import mept_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_status.div_done) begin
                    o_cmd.centre = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                // unchanged count: just repeat the held results
                if (i_status.same) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.turn = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_DTCHK;
            end
            S_DTCHK: begin
                if (i_status.dt_pos) begin
                    o_cmd.vel_start = 1'b1;
                    n_state         = S_VEL;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_VEL: begin
                if (i_status.div_done) begin
                    o_cmd.vel = 1'b1;
                    n_state   = S_ACC_GO;
                end
            end
            S_ACC_GO: begin
                o_cmd.acc_start = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                if (i_status.div_done) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_MOD))
        else $error("accepted request did not start re-centre");
    a_acc_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |=> o_cmd.commit) else $error("acceleration not followed by commit");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_OUT)) else $error("commit not followed by output");

endmodule

// File: rtl/multiturn_encoder_position_tracker_core.sv
// ============================================================================
// multiturn_encoder_position_tracker_core: multi-turn encoder tracker
// Re-centres absolute counts, tracks turns, forms position, velocity and
// acceleration, one result per sample request.
// ============================================================================
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  i_in    | in  | valid / ready | raw_count[15:0], time_ms[31:0]
//  o_out   | out | valid / ready | position, velocity, acceleration, turn_count
//  i_cfg   | in  | valid / ready | index[1:0], data[16:0] (ready always high)
//
//  One request at a time through a shared one-bit-per-cycle divider: a moving
//  sample with positive time step runs a 17-step re-centre plus two 33-step
//  divisions, one with no time step only the re-centre, as does an unchanged count.
//  Reset is synchronous, active low; config and tracking state take reset values.
//  A finished result waits in the output register; the next request is taken
//  meanwhile and holds in its last step until the register frees.
//
module multiturn_encoder_position_tracker_core
    import mept_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mept_in_if.sink     i_in,
    mept_out_if.source  o_out,
    mept_cfg_if.sink    i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // Sequencer
    mept_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath
    mept_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_raw_count    (i_in.raw_count),
        .i_time_ms      (i_in.time_ms),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_position     (o_out.position),
        .o_velocity     (o_out.velocity),
        .o_acceleration (o_out.acceleration),
        .o_turn_count   (o_out.turn_count),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule
